[sv/mahp_pkg.sv]
// Shared types, field codes and constant tables for the MPEG audio header parser.
// No dependencies; imported by mahp_frame_div, mpeg_audio_header_parse and the testbench.
`default_nettype none

package mahp_pkg;

  // Header field codes.
  localparam logic [10:0] SYNC_WORD     = 11'h7ff;
  localparam logic [1:0]  VER_MPEG25    = 2'd0;
  localparam logic [1:0]  VER_RESERVED  = 2'd1;
  localparam logic [1:0]  VER_MPEG2     = 2'd2;
  localparam logic [1:0]  VER_MPEG1     = 2'd3;
  localparam logic [1:0]  LAYER_RESERVED = 2'd0;
  localparam logic [1:0]  LAYER_III     = 2'd1;
  localparam logic [1:0]  LAYER_II      = 2'd2;
  localparam logic [1:0]  LAYER_I       = 2'd3;
  localparam logic [3:0]  BR_IDX_BAD    = 4'd15;
  localparam logic [1:0]  SR_IDX_0      = 2'd0;
  localparam logic [1:0]  SR_IDX_1      = 2'd1;
  localparam logic [1:0]  SR_IDX_2      = 2'd2;
  localparam logic [1:0]  SR_IDX_BAD    = 2'd3;
  localparam logic [1:0]  MODE_MONO     = 2'd3;

  // Widths of the internal datapath.
  localparam int NUM_W   = 26;  // coefficient times bitrate, below 2^26
  localparam int RECIP_W = 14;  // floor(2^26 / rate) for rates of 8000 and up
  localparam int FRAME_W = 12;
  localparam int RATE_W  = 16;
  localparam int BR_W    = 19;

  // Reciprocals of the sample rates, scaled by 2^RECIP_SHIFT and rounded down.
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] RECIP_44100 = RECIP_W'((2 ** RECIP_SHIFT) / 44100);
  localparam logic [RECIP_W-1:0] RECIP_48000 = RECIP_W'((2 ** RECIP_SHIFT) / 48000);
  localparam logic [RECIP_W-1:0] RECIP_32000 = RECIP_W'((2 ** RECIP_SHIFT) / 32000);
  localparam logic [RECIP_W-1:0] RECIP_22050 = RECIP_W'((2 ** RECIP_SHIFT) / 22050);
  localparam logic [RECIP_W-1:0] RECIP_24000 = RECIP_W'((2 ** RECIP_SHIFT) / 24000);
  localparam logic [RECIP_W-1:0] RECIP_16000 = RECIP_W'((2 ** RECIP_SHIFT) / 16000);
  localparam logic [RECIP_W-1:0] RECIP_11025 = RECIP_W'((2 ** RECIP_SHIFT) / 11025);
  localparam logic [RECIP_W-1:0] RECIP_12000 = RECIP_W'((2 ** RECIP_SHIFT) / 12000);
  localparam logic [RECIP_W-1:0] RECIP_8000  = RECIP_W'((2 ** RECIP_SHIFT) / 8000);

  // Bitrates in kbit/s; the last entry stands for the illegal index.
  localparam logic [8:0] KBPS_M1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_M1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_M1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_LSF_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_LSF_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Decoded header fields that travel down the pipeline beside the division.
  typedef struct packed {
    logic              ok;
    logic [RATE_W-1:0] rate_hz;
    logic [1:0]        channels;
    logic [BR_W-1:0]   bit_rate;
    logic [2:0]        pad_bytes;
  } hdr_info_t;

  // Request into the frame length divider.
  typedef struct packed {
    logic               valid;
    logic [NUM_W-1:0]   num;
    logic [RECIP_W-1:0] recip;
    hdr_info_t          info;
  } div_req_t;

  // Result out of the frame length divider.
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame_bytes;
    hdr_info_t          info;
  } div_rsp_t;

  // Bitrate in kbit/s for a given version class, layer code and index.
  function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] layer,
                                             input logic [3:0] idx);
    logic [8:0] k;
    k = '0;
    if (!lsf) begin
      case (layer)
        LAYER_I:  k = KBPS_M1_L1[idx];
        LAYER_II: k = KBPS_M1_L2[idx];
        default:  k = KBPS_M1_L3[idx];
      endcase
    end else begin
      case (layer)
        LAYER_I: k = KBPS_LSF_L1[idx];
        default: k = KBPS_LSF_L23[idx];
      endcase
    end
    return k;
  endfunction

  // Sample rate in hertz; zero for the reserved version or index.
  function automatic logic [RATE_W-1:0] rate_lookup(input logic [1:0] ver,
                                                    input logic [1:0] sr);
    logic [RATE_W-1:0] r;
    r = '0;
    case ({ver, sr})
      {VER_MPEG1, SR_IDX_0}:  r = 16'd44100;
      {VER_MPEG1, SR_IDX_1}:  r = 16'd48000;
      {VER_MPEG1, SR_IDX_2}:  r = 16'd32000;
      {VER_MPEG2, SR_IDX_0}:  r = 16'd22050;
      {VER_MPEG2, SR_IDX_1}:  r = 16'd24000;
      {VER_MPEG2, SR_IDX_2}:  r = 16'd16000;
      {VER_MPEG25, SR_IDX_0}: r = 16'd11025;
      {VER_MPEG25, SR_IDX_1}: r = 16'd12000;
      {VER_MPEG25, SR_IDX_2}: r = 16'd8000;
      default:                r = '0;
    endcase
    return r;
  endfunction

  // Scaled reciprocal of the sample rate; zero for illegal codes.
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [1:0] ver,
                                                      input logic [1:0] sr);
    logic [RECIP_W-1:0] q;
    q = '0;
    case ({ver, sr})
      {VER_MPEG1, SR_IDX_0}:  q = RECIP_44100;
      {VER_MPEG1, SR_IDX_1}:  q = RECIP_48000;
      {VER_MPEG1, SR_IDX_2}:  q = RECIP_32000;
      {VER_MPEG2, SR_IDX_0}:  q = RECIP_22050;
      {VER_MPEG2, SR_IDX_1}:  q = RECIP_24000;
      {VER_MPEG2, SR_IDX_2}:  q = RECIP_16000;
      {VER_MPEG25, SR_IDX_0}: q = RECIP_11025;
      {VER_MPEG25, SR_IDX_1}: q = RECIP_12000;
      {VER_MPEG25, SR_IDX_2}: q = RECIP_8000;
      default:                q = '0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

[sv/mahp_frame_div.sv]
// Three-stage divider of the frame length numerator by the sample rate.
// Uses a scaled reciprocal and one correction step; depends on mahp_pkg.
`default_nettype none

module mahp_frame_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire mahp_pkg::div_req_t req,
  output mahp_pkg::div_rsp_t      rsp
);
  import mahp_pkg::*;

  localparam int PROD_W = NUM_W + RECIP_W;
  localparam int QR_W   = FRAME_W + RATE_W;

  logic [PROD_W-1:0]  prod;
  logic [QR_W-1:0]    qr_full;
  logic [NUM_W-1:0]   rem;
  logic [FRAME_W-1:0] q_fix;

  // Stage A: quotient estimate, at most one below the true quotient.
  logic               va;
  logic [NUM_W-1:0]   num_a;
  logic [FRAME_W-1:0] q_a;
  hdr_info_t          info_a;

  // Stage B: estimate times divisor.
  logic               vb;
  logic [NUM_W-1:0]   num_b;
  logic [NUM_W-1:0]   qr_b;
  logic [FRAME_W-1:0] q_b;
  hdr_info_t          info_b;

  assign prod    = PROD_W'(req.num) * PROD_W'(req.recip);
  assign qr_full = QR_W'(q_a) * QR_W'(info_a.rate_hz);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a  <= req.num;
      q_a    <= prod[RECIP_SHIFT +: FRAME_W];
      info_a <= req.info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_b  <= num_a;
      qr_b   <= qr_full[NUM_W-1:0];
      q_b    <= q_a;
      info_b <= info_a;
    end
  end

  // Stage C: correct the estimate by one, add padding and clear invalid headers.
  assign rem   = num_b - qr_b;
  assign q_fix = (rem >= NUM_W'(info_b.rate_hz)) ? q_b + FRAME_W'(1) : q_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.frame_bytes <= info_b.ok ? q_fix + FRAME_W'(info_b.pad_bytes) : '0;
      rsp.info        <= info_b;
    end
  end

endmodule

`default_nettype wire

[sv/mpeg_audio_header_parse.sv]
// MPEG-1/2/2.5 audio frame header parser, top level.
// Depends on mahp_pkg and mahp_frame_div.
//
// Usage:
//   Input channel s_*: one 32-bit header word per request, first byte in bits 31..24.
//   Output channel m_*: one result per header. m_tuser carries header_ok; m_tdata
//   carries sample rate, channel count, bitrate in bit/s and frame length in bytes.
//   A header with bad sync or an illegal field gives header_ok low and zero fields.
// Pipeline: five register stages, the last of which drives m_tvalid. The stages
//   are field decode and table lookup, numerator multiply, reciprocal multiply,
//   quotient times rate, and the final correction with padding.
// Throughput: one header per cycle unless the output stalls; every stage holds one request.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops, so nothing is lost or repeated; an empty output stage lets
//   the pipeline move.
// Reset: rst clears all valid bits; the data registers are not reset.
`default_nettype none

module mpeg_audio_header_parse (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // header_word[31:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [55:0] m_tdata,   // sample_rate_hz[15:0], channel_count[17:16],
                                      // bit_rate[36:18], frame_bytes[48:37], zero fill
  output      logic [0:0]  m_tuser    // header_ok[0]
);
  import mahp_pkg::*;

  logic       en;
  logic [10:0] sync;
  logic [1:0]  ver;
  logic [1:0]  layer;
  logic [3:0]  br_idx;
  logic [1:0]  sr_idx;
  logic        pad;
  logic [1:0]  mode;
  logic        lsf;
  logic        legal;
  logic [8:0]  kbps;
  logic [7:0]  coef;
  hdr_info_t   info_d;

  // Stage 1 registers.
  logic               v1;
  hdr_info_t          info1;
  logic [7:0]         coef1;
  logic [RECIP_W-1:0] recip1;

  div_req_t req2;
  div_rsp_t rsp;

  // The pipeline moves unless a finished result is waiting on the receiver.
  assign en       = !rsp.valid || m_tready;
  assign s_tready = en;

  // Field split.
  assign sync   = s_tdata[31:21];
  assign ver    = s_tdata[20:19];
  assign layer  = s_tdata[18:17];
  assign br_idx = s_tdata[15:12];
  assign sr_idx = s_tdata[11:10];
  assign pad    = s_tdata[9];
  assign mode   = s_tdata[7:6];
  assign lsf    = (ver != VER_MPEG1);

  assign legal = (sync == SYNC_WORD) && (ver != VER_RESERVED) &&
                 (layer != LAYER_RESERVED) && (sr_idx != SR_IDX_BAD) &&
                 (br_idx != BR_IDX_BAD);

  assign kbps = kbps_lookup(lsf, layer, br_idx);

  // Frame length coefficient by layer and version class.
  always_comb begin
    case (layer)
      LAYER_I:   coef = 8'd48;
      LAYER_III: coef = lsf ? 8'd72 : 8'd144;
      default:   coef = 8'd144;
    endcase
  end

  // Decoded fields, forced to zero for an illegal header.
  always_comb begin
    info_d = '0;
    if (legal) begin
      info_d.ok          = 1'b1;
      info_d.rate_hz     = rate_lookup(ver, sr_idx);
      info_d.channels    = (mode == MODE_MONO) ? 2'd1 : 2'd2;
      info_d.bit_rate    = BR_W'(BR_W'(kbps) * BR_W'(1000));
      info_d.pad_bytes   = pad ? ((layer == LAYER_I) ? 3'd4 : 3'd1) : 3'd0;
    end
  end

  // Stage 1: decode and table lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info1  <= info_d;
      coef1  <= legal ? coef : 8'd0;
      recip1 <= legal ? recip_lookup(ver, sr_idx) : '0;
    end
  end

  // Stage 2: numerator of the frame length.
  always_ff @(posedge clk) begin
    if (rst) begin
      req2.valid <= 1'b0;
    end else if (en) begin
      req2.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req2.num   <= NUM_W'(NUM_W'(coef1) * NUM_W'(info1.bit_rate));
      req2.recip <= recip1;
      req2.info  <= info1;
    end
  end

  // Stages 3 to 5: division by the sample rate and output register.
  mahp_frame_div u_div (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (req2),
    .rsp (rsp)
  );

  assign m_tvalid = rsp.valid;
  assign m_tuser  = rsp.info.ok;
  assign m_tdata  = {7'd0, rsp.frame_bytes, rsp.info.bit_rate, rsp.info.channels,
                     rsp.info.rate_hz};

endmodule

`default_nettype wire

[test/mpeg_audio_header_parse_tb.sv]
// Self-checking testbench for the MPEG audio frame header parser.
// Needs mahp_pkg and the mpeg_audio_header_parse RTL; it predicts every result on its own.
`default_nettype none

module mpeg_audio_header_parse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mahp_pkg::*;

  localparam int STALL_LIMIT   = 1000;  // cycles with no request moving on either side
  localparam int DRAIN_CYCLES  = 16;    // wait after the last result, well over latency
  localparam int RANDOM_ITEMS  = 1400;
  localparam int REPORT_LIMIT  = 10;

  // Bitrate tables in kbit/s, index 0 in the lowest slot.
  localparam logic [14:0][8:0] M1_L1_KBPS = {9'd448, 9'd416, 9'd384, 9'd352, 9'd320,
    9'd288, 9'd256, 9'd224, 9'd192, 9'd160, 9'd128, 9'd96, 9'd64, 9'd32, 9'd0};
  localparam logic [14:0][8:0] M1_L2_KBPS = {9'd384, 9'd320, 9'd256, 9'd224, 9'd192,
    9'd160, 9'd128, 9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd32, 9'd0};
  localparam logic [14:0][8:0] M1_L3_KBPS = {9'd320, 9'd256, 9'd224, 9'd192, 9'd160,
    9'd128, 9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd0};
  localparam logic [14:0][8:0] LSF_L1_KBPS = {9'd256, 9'd224, 9'd192, 9'd176, 9'd160,
    9'd144, 9'd128, 9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd32, 9'd0};
  localparam logic [14:0][8:0] LSF_L23_KBPS = {9'd160, 9'd144, 9'd128, 9'd112, 9'd96,
    9'd80, 9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd24, 9'd16, 9'd8, 9'd0};

  // One decoded header as the block reports it.
  typedef struct packed {
    logic        ok;
    logic [15:0] rate;
    logic [1:0]  chans;
    logic [18:0] bps;
    logic [11:0] len;
  } frame_info_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;

  frame_info_t expected_frames[$];
  logic [31:0] expected_headers[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          sender_burst = 0;
  int          ready_left = 0;

  mpeg_audio_header_parse DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicts the result of one header word.
  function automatic frame_info_t decode_header(input logic [31:0] w);
    frame_info_t r;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic        lsf;
    int unsigned rate_hz;
    int unsigned kbps;
    int unsigned coef;
    int unsigned slot;
    int unsigned bps;
    int unsigned len;
    r   = '0;
    ver = w[20:19];
    lay = w[18:17];
    bri = w[15:12];
    sri = w[11:10];
    if (w[31:21] != SYNC_WORD || ver == VER_RESERVED || lay == LAYER_RESERVED ||
        sri == SR_IDX_BAD || bri == BR_IDX_BAD) begin
      return r;
    end
    lsf = (ver != VER_MPEG1);
    // MPEG-2 halves the MPEG-1 rates and MPEG-2.5 quarters them.
    case (sri)
      SR_IDX_0: rate_hz = 44100;
      SR_IDX_1: rate_hz = 48000;
      default:  rate_hz = 32000;
    endcase
    if (ver == VER_MPEG2) begin
      rate_hz = rate_hz / 2;
    end else if (ver == VER_MPEG25) begin
      rate_hz = rate_hz / 4;
    end
    case (lay)
      LAYER_I: begin
        kbps = lsf ? LSF_L1_KBPS[bri] : M1_L1_KBPS[bri];
        coef = 48;
        slot = 4;
      end
      LAYER_II: begin
        kbps = lsf ? LSF_L23_KBPS[bri] : M1_L2_KBPS[bri];
        coef = 144;
        slot = 1;
      end
      default: begin
        kbps = lsf ? LSF_L23_KBPS[bri] : M1_L3_KBPS[bri];
        coef = lsf ? 72 : 144;
        slot = 1;
      end
    endcase
    bps = kbps * 1000;
    len = coef * bps / rate_hz + (w[9] ? slot : 0);
    r.ok    = 1'b1;
    r.rate  = rate_hz[15:0];
    r.chans = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    r.bps   = bps[18:0];
    r.len   = len[11:0];
    return r;
  endfunction

  // Assembles a header with a good sync; misc fills protection, private and low bits.
  function automatic logic [31:0] build_header(input logic [1:0] ver, input logic [1:0] lay,
                                               input logic [3:0] br, input logic [1:0] sr,
                                               input logic pad, input logic [1:0] mode,
                                               input logic [7:0] misc);
    return {SYNC_WORD, ver, lay, misc[7], br, sr, pad, misc[6], mode, misc[5:0]};
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sends one header request, called at a falling edge and returning at one.
  task automatic send_header(input logic [31:0] w);
    int gap;
    if (sender_burst > 0) begin
      sender_burst--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 39) == 0) sender_burst = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_frames.push_back(decode_header(w));
    expected_headers.push_back(w);
    @(negedge clk);
  endtask

  // Bad sync, every reserved code, the illegal indexes and free format.
  task automatic test_special_cases();
    send_header(32'h0000_0000);
    // Lowest sync bit cleared on an otherwise legal header.
    send_header(build_header(VER_MPEG1, LAYER_III, 4'd9, SR_IDX_0, 1'b0,
                             2'd0, 8'h00) ^ 32'h0020_0000);
    send_header(build_header(VER_RESERVED, LAYER_II, 4'd5, SR_IDX_1, 1'b1, 2'd1, 8'hff));
    send_header(build_header(VER_MPEG1, LAYER_RESERVED, 4'd5, SR_IDX_1, 1'b1, 2'd1, 8'hff));
    send_header(build_header(VER_MPEG2, LAYER_III, 4'd7, SR_IDX_BAD, 1'b0, 2'd2, 8'h5a));
    send_header(build_header(VER_MPEG25, LAYER_I, BR_IDX_BAD, SR_IDX_2, 1'b1, 2'd3, 8'ha5));
    send_header(32'hffff_ffff);
    send_header(build_header(VER_MPEG1, LAYER_I, 4'd0, SR_IDX_0, 1'b1, 2'd0, 8'h00));
    send_header(build_header(VER_MPEG1, LAYER_II, 4'd0, SR_IDX_1, 1'b1, 2'd3, 8'hff));
    send_header(build_header(VER_MPEG2, LAYER_III, 4'd0, SR_IDX_2, 1'b1, 2'd1, 8'h00));
  endtask

  // Every version and layer, largest and smallest bitrates and rates, mono and stereo.
  task automatic test_field_extremes();
    send_header(build_header(VER_MPEG1, LAYER_I, 4'd14, SR_IDX_2, 1'b1, 2'd3, 8'hff));
    send_header(build_header(VER_MPEG1, LAYER_II, 4'd14, SR_IDX_2, 1'b1, 2'd0, 8'h00));
    send_header(build_header(VER_MPEG1, LAYER_III, 4'd14, SR_IDX_0, 1'b0, 2'd0, 8'hff));
    send_header(build_header(VER_MPEG1, LAYER_III, 4'd1, SR_IDX_1, 1'b0, 2'd2, 8'h00));
    send_header(build_header(VER_MPEG2, LAYER_I, 4'd14, SR_IDX_2, 1'b1, 2'd1, 8'hff));
    send_header(build_header(VER_MPEG2, LAYER_II, 4'd1, SR_IDX_1, 1'b0, 2'd3, 8'h00));
    send_header(build_header(VER_MPEG2, LAYER_III, 4'd14, SR_IDX_0, 1'b1, 2'd3, 8'hff));
    send_header(build_header(VER_MPEG25, LAYER_III, 4'd14, SR_IDX_2, 1'b1, 2'd2, 8'h00));
    send_header(build_header(VER_MPEG25, LAYER_II, 4'd14, SR_IDX_2, 1'b1, 2'd0, 8'hff));
    send_header(build_header(VER_MPEG25, LAYER_I, 4'd1, SR_IDX_0, 1'b0, 2'd1, 8'h00));
  endtask

  // Mostly legal headers with random content, the rest broken headers and noise.
  task automatic test_random_stream(input int count);
    logic [31:0] w;
    logic [1:0]  ver;
    int          kind;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 2))
        0:       ver = VER_MPEG25;
        1:       ver = VER_MPEG2;
        default: ver = VER_MPEG1;
      endcase
      w = build_header(ver, 2'($urandom_range(1, 3)), 4'($urandom_range(0, 14)),
                       2'($urandom_range(0, 2)), 1'($urandom()), 2'($urandom()),
                       8'($urandom()));
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
        w = $urandom();
      end else if (kind >= 70) begin
        // Break exactly one field of an otherwise legal header.
        case ($urandom_range(0, 4))
          0:       w[31:21] = w[31:21] ^ (11'd1 << $urandom_range(0, 10));
          1:       w[20:19] = VER_RESERVED;
          2:       w[18:17] = LAYER_RESERVED;
          3:       w[15:12] = BR_IDX_BAD;
          default: w[11:10] = SR_IDX_BAD;
        endcase
      end
      send_header(w);
    end
  endtask

  // Result side readiness: short and long stalls, with stretches of no stall at all.
  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          m_tready   <= 1'b1;
          ready_left <= $urandom_range(20, 80);
        end
        1, 2, 3: begin
          m_tready   <= 1'b0;
          ready_left <= pick_gap();
        end
        default: begin
          m_tready   <= 1'b1;
          ready_left <= $urandom_range(0, 5);
        end
      endcase
    end
  end

  // Compares each accepted result with the oldest pending prediction.
  always @(posedge clk) begin
    frame_info_t got;
    frame_info_t want;
    logic [31:0] hdr;
    if (!rst && m_tvalid && m_tready) begin
      got.ok    = m_tuser[0];
      got.rate  = m_tdata[15:0];
      got.chans = m_tdata[17:16];
      got.bps   = m_tdata[36:18];
      got.len   = m_tdata[48:37];
      if (expected_frames.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("unexpected result with no header pending: ok=%0d rate=%0d ch=%0d",
                   got.ok, got.rate, got.chans);
        end
      end else begin
        want = expected_frames.pop_front();
        hdr  = expected_headers.pop_front();
        if (got.ok !== want.ok || got.rate !== want.rate || got.chans !== want.chans ||
            got.bps !== want.bps || got.len !== want.len) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("mismatch for header %h: expected ok=%0d rate=%0d ch=%0d bps=%0d len=%0d",
                     hdr, want.ok, want.rate, want.chans, want.bps, want.len);
            $display("                          got ok=%0d rate=%0d ch=%0d bps=%0d len=%0d",
                     got.ok, got.rate, got.chans, got.bps, got.len);
          end
        end
      end
    end
  end

  // Ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, then the tests in turn, then drain and report.
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_field_extremes();
    test_random_stream(RANDOM_ITEMS);
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
